// ----- rtl/dle_pkg.sv -----
// Shared types and codes for the double-ended list engine.
// Used by the command queue, the executor and the top level.
package dle_pkg;

    localparam int DLE_CAPACITY   = 64;
    localparam int DLE_DATA_WIDTH = 32;

    // command codes on the op field
    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_POP_FRONT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_ERASE_AT   = 4'd4;
    localparam logic [3:0] OP_REVERSE    = 4'd5;
    localparam logic [3:0] OP_UNIQUE     = 4'd6;
    localparam logic [3:0] OP_CLEAR      = 4'd7;
    localparam logic [3:0] OP_ASSIGN     = 4'd8;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [3:0] {
        K_PUSH_F, K_PUSH_B, K_POP_F, K_POP_B, K_ERASE,
        K_REV, K_UNIQ, K_CLEAR, K_ASSIGN, K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] element;
        logic [5:0]  position;
        logic [6:0]  repeat_count;
    } t_cmd;

    // queue handshake toward the executor
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// ----- rtl/dle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/dle_front.sv -----
// Command front end: takes items, decodes the op and holds them in a
// two-entry queue for the executor. Depends on dle_pkg.
module dle_front import dle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_op,
    input  logic [31:0] i_element,
    input  logic [5:0]  i_position,
    input  logic [6:0]  i_repeat_count,
    input  logic        i_pop,
    output t_q_head     o_head
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push;

    // classify the op field
    always_comb begin
        dec.element      = i_element;
        dec.position     = i_position;
        dec.repeat_count = i_repeat_count;
        unique case (i_op)
            OP_PUSH_FRONT: dec.kind = K_PUSH_F;
            OP_PUSH_BACK:  dec.kind = K_PUSH_B;
            OP_POP_FRONT:  dec.kind = K_POP_F;
            OP_POP_BACK:   dec.kind = K_POP_B;
            OP_ERASE_AT:   dec.kind = K_ERASE;
            OP_REVERSE:    dec.kind = K_REV;
            OP_UNIQUE:     dec.kind = K_UNIQ;
            OP_CLEAR:      dec.kind = K_CLEAR;
            OP_ASSIGN:     dec.kind = K_ASSIGN;
            default:       dec.kind = K_NOP;
        endcase
    end

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy;

    // hold decoded items until the executor takes them
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];
endmodule

// ----- rtl/dle_back.sv -----
// Command executor: runs each queued item against the ring store and
// issues one result. Depends on dle_pkg and dle_ram.
module dle_back import dle_pkg::*; #(
    parameter int CAPACITY   = DLE_CAPACITY,
    parameter int DATA_WIDTH = DLE_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_head,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_popped_value,
    output logic [31:0] o_front_value,
    output logic [31:0] o_back_value,
    output logic [6:0]  o_entry_count,
    output logic        o_is_empty
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 7) ? CW : 7) + 1;
    localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001, S_EXEC     = 15'h0002, S_POP_WAIT = 15'h0004,
        S_ERASE_RD = 15'h0008, S_ERASE_WR = 15'h0010, S_UQ_RD    = 15'h0020,
        S_UQ_LOAD  = 15'h0040, S_UQ_SCAN  = 15'h0080, S_UQ_CMP   = 15'h0100,
        S_CP_RD    = 15'h0200, S_CP_WR    = 15'h0400, S_AS_WR    = 15'h0800,
        S_FRONT_RD = 15'h1000, S_BACK_RD  = 15'h2000, S_DONE     = 15'h4000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_cnt, n_cnt, r_i, n_i, r_j, n_j, r_n, n_n;
    logic                  r_rev, n_rev, r_seen, n_seen;
    logic [DATA_WIDTH-1:0] r_val, n_val, r_front, n_front, r_popped, n_popped;
    logic [1:0]            r_status, n_status;

    logic                  r_ostb, n_ostb;
    logic [1:0]            r_ost, n_ost;
    logic [31:0]           r_opop, n_opop, r_ofr, n_ofr, r_obk, n_obk;
    logic [6:0]            r_ocnt, n_ocnt;
    logic                  r_oemp, n_oemp;

    logic                  s_we, t_we;
    logic [AW-1:0]         s_waddr, s_raddr, t_waddr, t_raddr;
    logic [DATA_WIDTH-1:0] s_wdata, s_rdata, t_wdata, t_rdata, elem;

    // ring position of logical entry idx
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] cnt,
                                           input logic rev,
                                           input logic [CW-1:0] idx);
        logic [CW-1:0] off;
        logic [CW:0]   sum;
        off = rev ? (cnt - 1'b1 - idx) : idx;
        sum = (CW + 1)'(head) + (CW + 1)'(off);
        if (sum >= CAP_W) begin
            sum = sum - CAP_W;
        end
        return AW'(sum);
    endfunction

    function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
        return (p == '0) ? LAST_A : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == LAST_A) ? '0 : p + 1'b1;
    endfunction

    assign elem = DATA_WIDTH'(r_cmd.element);

    dle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // scratch list of distinct values for unique
    dle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_scratch (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    // sequence each command
    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_head = r_head; n_cnt = r_cnt;
        n_i = r_i; n_j = r_j; n_n = r_n; n_rev = r_rev; n_seen = r_seen;
        n_val = r_val; n_front = r_front; n_popped = r_popped;
        n_status = r_status;
        n_ostb = 1'b0; n_ost = r_ost; n_opop = r_opop; n_ofr = r_ofr;
        n_obk = r_obk; n_ocnt = r_ocnt; n_oemp = r_oemp;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
        o_pop = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_head.cmd;
                    n_status = ST_OK;
                    n_popped = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FRONT_RD;
                unique case (r_cmd.kind)
                    K_PUSH_F, K_PUSH_B: begin
                        if ((CW + 1)'(r_cnt) >= CAP_W) begin
                            n_status = ST_FULL;
                        end else begin
                            s_we    = 1'b1;
                            s_wdata = elem;
                            n_cnt   = r_cnt + 1'b1;
                            if ((r_cmd.kind == K_PUSH_F) != r_rev) begin
                                n_head  = dec_ptr(r_head);
                                s_waddr = n_head;
                            end else begin
                                s_waddr = phys(r_head, r_cnt, 1'b0, r_cnt);
                            end
                        end
                    end
                    K_POP_F, K_POP_B: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            s_raddr = phys(r_head, r_cnt, r_rev,
                                (r_cmd.kind == K_POP_F) ? '0 : r_cnt - 1'b1);
                            n_state = S_POP_WAIT;
                        end
                    end
                    K_ERASE: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                        end else if (XW'(r_cmd.position) >= XW'(r_cnt)) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_i     = CW'(r_cmd.position);
                            n_state = S_ERASE_RD;
                        end
                    end
                    K_REV: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_rev = ~r_rev;
                        end
                    end
                    K_UNIQ: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_i     = '0;
                            n_n     = '0;
                            n_state = S_UQ_RD;
                        end
                    end
                    K_CLEAR: begin
                        n_cnt  = '0;
                        n_head = '0;
                        n_rev  = 1'b0;
                    end
                    K_ASSIGN: begin
                        if (XW'(r_cnt) + XW'(r_cmd.repeat_count) > XW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_i     = CW'(r_cmd.repeat_count);
                            n_state = S_AS_WR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POP_WAIT: begin
                n_popped = s_rdata;
                n_cnt    = r_cnt - 1'b1;
                if ((r_cmd.kind == K_POP_F) != r_rev) begin
                    n_head = inc_ptr(r_head);
                end
                n_state = S_FRONT_RD;
            end
            // shift later entries down one place, then drop the last
            S_ERASE_RD: begin
                if ((CW + 1)'(r_i) + 1'b1 < (CW + 1)'(r_cnt)) begin
                    s_raddr = phys(r_head, r_cnt, r_rev, r_i + 1'b1);
                    n_state = S_ERASE_WR;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_rev) begin
                        n_head = inc_ptr(r_head);
                    end
                    n_state = S_FRONT_RD;
                end
            end
            S_ERASE_WR: begin
                s_we    = 1'b1;
                s_waddr = phys(r_head, r_cnt, r_rev, r_i);
                s_wdata = s_rdata;
                n_i     = r_i + 1'b1;
                n_state = S_ERASE_RD;
            end
            // walk entries, keep each value not yet seen
            S_UQ_RD: begin
                if (r_i < r_cnt) begin
                    s_raddr = phys(r_head, r_cnt, r_rev, r_i);
                    n_state = S_UQ_LOAD;
                end else begin
                    n_j     = '0;
                    n_state = S_CP_RD;
                end
            end
            S_UQ_LOAD: begin
                n_val   = s_rdata;
                n_j     = '0;
                n_seen  = 1'b0;
                n_state = S_UQ_SCAN;
            end
            S_UQ_SCAN: begin
                if (r_j < r_n) begin
                    t_raddr = AW'(r_j);
                    n_state = S_UQ_CMP;
                end else begin
                    if (!r_seen) begin
                        t_we    = 1'b1;
                        t_waddr = AW'(r_n);
                        t_wdata = r_val;
                        n_n     = r_n + 1'b1;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_UQ_RD;
                end
            end
            S_UQ_CMP: begin
                if (t_rdata == r_val) begin
                    n_seen = 1'b1;
                end
                n_j     = r_j + 1'b1;
                n_state = S_UQ_SCAN;
            end
            // copy the distinct list back from ring position zero
            S_CP_RD: begin
                if (r_j < r_n) begin
                    t_raddr = AW'(r_j);
                    n_state = S_CP_WR;
                end else begin
                    n_head  = '0;
                    n_rev   = 1'b0;
                    n_cnt   = r_n;
                    n_state = S_FRONT_RD;
                end
            end
            S_CP_WR: begin
                s_we    = 1'b1;
                s_waddr = AW'(r_j);
                s_wdata = t_rdata;
                n_j     = r_j + 1'b1;
                n_state = S_CP_RD;
            end
            // append one copy per cycle at the back
            S_AS_WR: begin
                if (r_i != '0) begin
                    s_we    = 1'b1;
                    s_wdata = elem;
                    n_cnt   = r_cnt + 1'b1;
                    n_i     = r_i - 1'b1;
                    if (r_rev) begin
                        n_head  = dec_ptr(r_head);
                        s_waddr = n_head;
                    end else begin
                        s_waddr = phys(r_head, r_cnt, 1'b0, r_cnt);
                    end
                end else begin
                    n_state = S_FRONT_RD;
                end
            end
            S_FRONT_RD: begin
                s_raddr = phys(r_head, r_cnt, r_rev, '0);
                n_state = S_BACK_RD;
            end
            S_BACK_RD: begin
                n_front = s_rdata;
                s_raddr = phys(r_head, r_cnt, r_rev, r_cnt - 1'b1);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_ostb  = 1'b1;
                n_ost   = r_status;
                n_opop  = 32'(r_popped);
                n_ofr   = (r_cnt != '0) ? 32'(r_front) : '0;
                n_obk   = (r_cnt != '0) ? 32'(s_rdata) : '0;
                n_ocnt  = 7'(r_cnt);
                n_oemp  = (r_cnt == '0);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // advance state
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_i <= n_i; r_j <= n_j; r_n <= n_n;
        r_seen <= n_seen; r_val <= n_val; r_front <= n_front;
        r_popped <= n_popped; r_status <= n_status;
        r_ost <= n_ost; r_opop <= n_opop; r_ofr <= n_ofr; r_obk <= n_obk;
        r_ocnt <= n_ocnt; r_oemp <= n_oemp;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_cnt   <= '0;
            r_rev   <= 1'b0;
            r_ostb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_rev   <= n_rev;
            r_ostb  <= n_ostb;
        end
    end

    assign o_strobe       = r_ostb;
    assign o_status       = r_ost;
    assign o_popped_value = r_opop;
    assign o_front_value  = r_ofr;
    assign o_back_value   = r_obk;
    assign o_entry_count  = r_ocnt;
    assign o_is_empty     = r_oemp;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + 1)'(r_cnt) <= CAP_W) else $error("entry count above capacity");
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE)) else $error("result without finish");
    a_uniq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UQ_RD) |-> (r_n <= r_i)) else $error("unique list overran input");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && i_head.valid) else $error("bad queue pop");
endmodule

// ----- rtl/double_ended_list_engine_unit.sv -----
// Bounded double-ended list engine: one command per item, one result per item,
// result shown on the ports with o_strobe high for one cycle (no back-pressure).
// Push, reverse, clear, unused codes and any refused command pass through
// queue, execute, front read, back read and result; an accepted pop also waits
// for the read data. Erase reads and rewrites each entry behind the position,
// assign writes the copies at the back in turn, and unique checks each of n
// entries against the d distinct values kept in a scratch RAM, then copies them
// back; each RAM has a single read port. The executor returns to idle after each
// result and takes no new item while one is still in progress.
// busy rises when the two-item queue is full.
// Depends on dle_pkg, dle_front, dle_back and dle_ram.
module double_ended_list_engine_unit import dle_pkg::*; #(
    parameter int CAPACITY   = DLE_CAPACITY,
    parameter int DATA_WIDTH = DLE_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_op,
    input  logic [31:0] i_element,
    input  logic [5:0]  i_position,
    input  logic [6:0]  i_repeat_count,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_popped_value,
    output logic [31:0] o_front_value,
    output logic [31:0] o_back_value,
    output logic [6:0]  o_entry_count,
    output logic        o_is_empty
);
    t_q_head q_head;
    logic    q_pop;

    dle_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_element(i_element), .i_position(i_position),
        .i_repeat_count(i_repeat_count), .i_pop(q_pop), .o_head(q_head)
    );

    dle_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(q_head), .o_pop(q_pop),
        .o_strobe(o_strobe), .o_status(o_status),
        .o_popped_value(o_popped_value), .o_front_value(o_front_value),
        .o_back_value(o_back_value), .o_entry_count(o_entry_count),
        .o_is_empty(o_is_empty)
    );
endmodule
